FILE: src/tcw_pkg.sv
package tcw_pkg;

    // field widths of the request and result
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;

    // operation codes
    localparam op_t OP_PUTC    = 3'd0;
    localparam op_t OP_CLEAR   = 3'd1;
    localparam op_t OP_COLOR   = 3'd2;
    localparam op_t OP_SAVE    = 3'd3;
    localparam op_t OP_RESTORE = 3'd4;
    localparam op_t OP_READ    = 3'd5;

    // special character codes and reset attribute
    localparam byte_t CHAR_BACKSPACE = 8'h08;
    localparam byte_t CHAR_NEWLINE   = 8'h0A;
    localparam byte_t CHAR_SPACE     = 8'h20;
    localparam byte_t RESET_COLOR    = 8'h0C;

    typedef struct packed {
        byte_t color;
        byte_t ch;
    } cell_t;

endpackage

FILE: src/text_console_writer_unit.sv
// Text console writer: a NUM_ROWS x NUM_COLS screen of character/attribute cells with a
// linear cursor, plus a second store for save and restore. Each request carries one
// operation and yields exactly one result with the cursor after it (and the cell
// contents for a read). Both stores sit in single-port-read, single-port-write
// synchronous RAMs. A plain character or backspace goes through the EXEC and DONE states,
// a read through EXEC, RDWAIT and DONE; newline on the last row, a character that fills
// the last cell, clear, set color, save and restore sweep the whole screen one cell per
// cycle through the RAM read/write pipeline, then drain and finish in DONE. After reset
// a clearing pass writes the blank cell into both RAMs, during which no request is
// taken. A request can be accepted while the previous result still waits in the output
// register.
module text_console_writer_unit #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 80
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcw_pkg::op_t          op,
    input  tcw_pkg::byte_t        char_code,
    input  tcw_pkg::byte_t        color_value,
    input  tcw_pkg::pos_t         cell_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tcw_pkg::pos_t         cursor_pos,
    output tcw_pkg::byte_t        read_char,
    output tcw_pkg::byte_t        read_color
);

    localparam int CELL_COUNT = NUM_ROWS * NUM_COLS;
    localparam int LAST_ROW   = CELL_COUNT - NUM_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int COL_W      = $clog2(NUM_COLS);
    // wide enough to compare the request index against the cell count
    localparam int WIDE_W     = ((ADDR_W > tcw_pkg::POS_W) ? ADDR_W : tcw_pkg::POS_W) + 1;

    typedef logic [ADDR_W-1:0] addr_t;

    // controller states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_SWEEP  = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    // what a full-screen sweep does to each cell
    typedef enum logic [2:0] {
        MODE_INIT,
        MODE_CLEAR,
        MODE_COLOR,
        MODE_SCROLL,
        MODE_SAVE,
        MODE_RESTORE
    } mode_t;

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    addr_t           ptr_reg, ptr_next;
    addr_t           cursor_reg, cursor_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    tcw_pkg::byte_t  color_reg, color_next;
    logic            wr_v_reg, wr_v_next;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    tcw_pkg::op_t    op_reg;
    tcw_pkg::byte_t  char_reg;
    tcw_pkg::byte_t  color_in_reg;
    tcw_pkg::pos_t   idx_reg;
    addr_t           wr_addr_reg;
    logic            wr_blank_reg, wr_blank_next;
    logic            rd_ok_reg, rd_ok_next;
    tcw_pkg::byte_t  res_char_reg, res_char_next;
    tcw_pkg::byte_t  res_color_reg, res_color_next;
    tcw_pkg::pos_t   out_pos_reg;
    tcw_pkg::byte_t  out_char_reg;
    tcw_pkg::byte_t  out_color_reg;

    // ---------------------------------------------------------------
    // memories and their ports
    // ---------------------------------------------------------------
    tcw_pkg::cell_t  screen_mem [CELL_COUNT];
    tcw_pkg::cell_t  saved_mem  [CELL_COUNT];

    logic            scr_re, scr_we, sav_re, sav_we;
    addr_t           scr_raddr, scr_waddr;
    tcw_pkg::cell_t  scr_wdata, sav_wdata;
    tcw_pkg::cell_t  scr_rdata_reg, sav_rdata_reg;

    logic            put_we;
    addr_t           put_addr;
    tcw_pkg::cell_t  put_data;
    tcw_pkg::cell_t  blank_cell;
    logic            out_load;
    logic [ADDR_W:0] scroll_src;

    assign blank_cell = '{color: color_reg, ch: tcw_pkg::CHAR_SPACE};
    // source row for a scroll is one row below the cell being written
    assign scroll_src = {1'b0, ptr_reg} + (ADDR_W + 1)'(NUM_COLS);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cursor_pos = out_pos_reg;
    assign read_char  = out_char_reg;
    assign read_color = out_color_reg;

    // ---------------------------------------------------------------
    // controller
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        color_next     = color_reg;
        wr_v_next      = 1'b0;
        wr_blank_next  = 1'b0;
        rd_ok_next     = rd_ok_reg;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        put_we         = 1'b0;
        put_addr       = cursor_reg;
        put_data       = blank_cell;
        scr_re         = 1'b0;
        scr_raddr      = ptr_reg;
        sav_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // non-read operations answer with zero cell fields
                res_char_next  = '0;
                res_color_next = '0;
                state_next     = ST_DONE;
                unique case (op_reg)
                    tcw_pkg::OP_PUTC:
                    begin
                        if (char_reg == tcw_pkg::CHAR_BACKSPACE)
                        begin
                            // backspace at the origin leaves everything alone
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - addr_t'(1);
                                put_we      = 1'b1;
                                put_addr    = cursor_reg - addr_t'(1);
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(NUM_COLS - 1);
                                    row_next = row_reg - ROW_W'(1);
                                end
                                else
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                            end
                        end
                        else if (char_reg == tcw_pkg::CHAR_NEWLINE)
                        begin
                            if (row_reg != ROW_W'(NUM_ROWS - 1))
                            begin
                                cursor_next = cursor_reg + addr_t'(NUM_COLS)
                                              - addr_t'(col_reg);
                                row_next    = row_reg + ROW_W'(1);
                                col_next    = '0;
                            end
                            else
                            begin
                                // newline on the last row scrolls
                                cursor_next = addr_t'(LAST_ROW);
                                col_next    = '0;
                                mode_next   = MODE_SCROLL;
                                ptr_next    = '0;
                                state_next  = ST_SWEEP;
                            end
                        end
                        else
                        begin
                            put_we   = 1'b1;
                            put_data = '{color: color_reg, ch: char_reg};
                            if (cursor_reg == addr_t'(CELL_COUNT - 1))
                            begin
                                // filling the last cell scrolls
                                cursor_next = addr_t'(LAST_ROW);
                                col_next    = '0;
                                mode_next   = MODE_SCROLL;
                                ptr_next    = '0;
                                state_next  = ST_SWEEP;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + addr_t'(1);
                                if (col_reg == COL_W'(NUM_COLS - 1))
                                begin
                                    col_next = '0;
                                    row_next = row_reg + ROW_W'(1);
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                        end
                    end

                    tcw_pkg::OP_CLEAR:
                    begin
                        cursor_next = '0;
                        row_next    = '0;
                        col_next    = '0;
                        mode_next   = MODE_CLEAR;
                        ptr_next    = '0;
                        state_next  = ST_SWEEP;
                    end

                    tcw_pkg::OP_COLOR:
                    begin
                        color_next = color_in_reg;
                        mode_next  = MODE_COLOR;
                        ptr_next   = '0;
                        state_next = ST_SWEEP;
                    end

                    tcw_pkg::OP_SAVE:
                    begin
                        mode_next  = MODE_SAVE;
                        ptr_next   = '0;
                        state_next = ST_SWEEP;
                    end

                    tcw_pkg::OP_RESTORE:
                    begin
                        mode_next  = MODE_RESTORE;
                        ptr_next   = '0;
                        state_next = ST_SWEEP;
                    end

                    tcw_pkg::OP_READ:
                    begin
                        // an index past the screen reads as zero
                        rd_ok_next = (WIDE_W'(idx_reg) < WIDE_W'(CELL_COUNT));
                        scr_re     = (WIDE_W'(idx_reg) < WIDE_W'(CELL_COUNT));
                        scr_raddr  = addr_t'(idx_reg);
                        state_next = ST_RDWAIT;
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SWEEP:
            begin
                // issue the read for this cell, write it back in the next cycle
                wr_v_next = 1'b1;
                case (mode_reg)
                    MODE_SCROLL:
                    begin
                        scr_re        = (ptr_reg < addr_t'(LAST_ROW));
                        scr_raddr     = scroll_src[ADDR_W-1:0];
                        wr_blank_next = (ptr_reg >= addr_t'(LAST_ROW));
                    end
                    MODE_COLOR, MODE_SAVE:
                    begin
                        scr_re = 1'b1;
                    end
                    MODE_RESTORE:
                    begin
                        sav_re = 1'b1;
                    end
                    default:
                    begin
                        wr_blank_next = 1'b1;
                    end
                endcase
                if (ptr_reg == addr_t'(CELL_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + addr_t'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = (mode_reg == MODE_INIT) ? ST_IDLE : ST_DONE;
            end

            ST_RDWAIT:
            begin
                res_char_next  = rd_ok_reg ? scr_rdata_reg.ch    : '0;
                res_color_next = rd_ok_reg ? scr_rdata_reg.color : '0;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // write-back stage of the sweep and direct character writes
    // ---------------------------------------------------------------
    always_comb
    begin
        scr_we    = put_we;
        scr_waddr = put_addr;
        scr_wdata = put_data;
        sav_we    = 1'b0;
        sav_wdata = blank_cell;
        if (wr_v_reg)
        begin
            scr_waddr = wr_addr_reg;
            scr_wdata = blank_cell;
            case (mode_reg)
                MODE_INIT:
                begin
                    scr_we = 1'b1;
                    sav_we = 1'b1;
                end
                MODE_CLEAR:
                begin
                    scr_we = 1'b1;
                end
                MODE_SCROLL:
                begin
                    scr_we    = 1'b1;
                    scr_wdata = wr_blank_reg ? blank_cell : scr_rdata_reg;
                end
                MODE_COLOR:
                begin
                    scr_we    = 1'b1;
                    scr_wdata = '{color: color_reg, ch: scr_rdata_reg.ch};
                end
                MODE_SAVE:
                begin
                    scr_we    = 1'b0;
                    sav_we    = 1'b1;
                    sav_wdata = scr_rdata_reg;
                end
                MODE_RESTORE:
                begin
                    scr_we    = 1'b1;
                    scr_wdata = sav_rdata_reg;
                end
                default:
                begin
                    scr_we = 1'b0;
                end
            endcase
        end
    end

    // screen and saved stores
    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re)
        begin
            scr_rdata_reg <= screen_mem[scr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sav_we)
        begin
            saved_mem[wr_addr_reg] <= sav_wdata;
        end
        if (sav_re)
        begin
            sav_rdata_reg <= saved_mem[ptr_reg];
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts the clearing pass over both stores
            state_reg     <= ST_SWEEP;
            mode_reg      <= MODE_INIT;
            ptr_reg       <= '0;
            cursor_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= tcw_pkg::RESET_COLOR;
            wr_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            cursor_reg    <= cursor_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            color_reg     <= color_next;
            wr_v_reg      <= wr_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg       <= op;
            char_reg     <= char_code;
            color_in_reg <= color_value;
            idx_reg      <= cell_index;
        end
        wr_addr_reg   <= ptr_reg;
        wr_blank_reg  <= wr_blank_next;
        rd_ok_reg     <= rd_ok_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        if (out_load)
        begin
            out_pos_reg   <= tcw_pkg::pos_t'(cursor_reg);
            out_char_reg  <= res_char_reg;
            out_color_reg <= res_color_reg;
        end
    end

endmodule

FILE: src/tcw_checker.sv
module tcw_checker #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 80
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  tcw_pkg::op_t    op,
    input  tcw_pkg::byte_t  char_code,
    input  tcw_pkg::byte_t  color_value,
    input  tcw_pkg::pos_t   cell_index,
    input  logic            out_valid,
    input  logic            out_ready,
    input  tcw_pkg::pos_t   cursor_pos,
    input  tcw_pkg::byte_t  read_char,
    input  tcw_pkg::byte_t  read_color
);

    localparam int CELL_COUNT = NUM_ROWS * NUM_COLS;

    logic           in_fire, out_fire;
    logic [1:0]     pend_reg;
    tcw_pkg::op_t   last_op_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // requests accepted whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_fire) - 2'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            last_op_reg <= op;
        end
    end

    // a waiting result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_pos)
        && $stable(read_char) && $stable(read_color))
    else $error("result changed while stalled");

    // one request at a time in the core
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
    else $error("request taken while busy");

    // no result without a request behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
    else $error("result without request");

    // cursor in range and cell fields zero except for a read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pend_reg == 2'd1 && last_op_reg != tcw_pkg::OP_READ
        |-> read_char == '0 && read_color == '0
        && 32'(cursor_pos) < CELL_COUNT)
    else $error("bad result fields");

endmodule

bind text_console_writer_unit tcw_checker #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
) u_tcw_checker (.*);

FILE: tb/text_console_writer_unit_test.sv
`timescale 1ns / 100ps

module text_console_writer_unit_test;

    // screen geometry, kept equal to the block's defaults
    localparam int NUM_ROWS  = 25;
    localparam int NUM_COLS  = 80;
    localparam int NUM_CELLS = NUM_ROWS * NUM_COLS;
    localparam int LAST_ROW  = NUM_CELLS - NUM_COLS;

    // op codes the block leaves unused: they only answer with the cursor
    localparam tcw_pkg::op_t OP_SPARE_A = 3'd6;
    localparam tcw_pkg::op_t OP_SPARE_B = 3'd7;

    // stimulus sizes
    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_COUNT   = 200;
    localparam int FILL_AT        = 20;

    // long receiver hold-off, started once this many results are in;
    // long enough to outlast two full-screen sweeps
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 5000;

    // one expected result
    typedef struct packed {
        tcw_pkg::pos_t  pos;
        tcw_pkg::byte_t ch;
        tcw_pkg::byte_t col;
    } answer_t;

    // one row of the directed table; the answer is only used when typed is set
    typedef struct packed {
        tcw_pkg::op_t   op;
        tcw_pkg::byte_t ch;
        tcw_pkg::byte_t col;
        tcw_pkg::pos_t  idx;
        bit             typed;
        tcw_pkg::pos_t  want_pos;
        tcw_pkg::byte_t want_ch;
        tcw_pkg::byte_t want_col;
    } step_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    tcw_pkg::op_t   op;
    tcw_pkg::byte_t char_code;
    tcw_pkg::byte_t color_value;
    tcw_pkg::pos_t  cell_index;
    logic           out_valid;
    logic           out_ready;
    tcw_pkg::pos_t  cursor_pos;
    tcw_pkg::byte_t read_char;
    tcw_pkg::byte_t read_color;

    // predictor state: visible screen, backup screen, cursor and pen color
    tcw_pkg::cell_t screen_img [NUM_CELLS];
    tcw_pkg::cell_t backup_img [NUM_CELLS];
    tcw_pkg::pos_t  cursor_now;
    tcw_pkg::byte_t pen_color;

    answer_t pending_answers [$];
    int      fail_count   = 0;
    int      answers_seen = 0;

    // idle rates in percent, changed by the stimulus as the run moves on
    int tx_idle_pct = 9;
    int rx_idle_pct = 60;

    // directed table: reset contents, extremes of every field, every op,
    // backspace at origin, unused ops, out-of-range reads, save/restore round trip
    step_t directed_steps [DIRECTED_COUNT] = '{
        // reads of the reset screen, then out-of-range reads return zero
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0, 1'b1, 11'd0,
          tcw_pkg::CHAR_SPACE, tcw_pkg::RESET_COLOR},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd1999, 1'b1, 11'd0,
          tcw_pkg::CHAR_SPACE, tcw_pkg::RESET_COLOR},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd2000, 1'b1, 11'd0, 8'h00, 8'h00},
        '{tcw_pkg::OP_READ, 8'hFF, 8'hFF, 11'h7FF,  1'b1, 11'd0, 8'h00, 8'h00},
        // backspace at the origin leaves everything alone
        '{tcw_pkg::OP_PUTC, tcw_pkg::CHAR_BACKSPACE, 8'h00, 11'd0, 1'b1, 11'd0,
          8'h00, 8'h00},
        // unused codes only report the cursor
        '{OP_SPARE_A, 8'h00, 8'h00, 11'd0,   1'b1, 11'd0, 8'h00, 8'h00},
        '{OP_SPARE_B, 8'hFF, 8'hFF, 11'h7FF, 1'b1, 11'd0, 8'h00, 8'h00},
        // plain bytes, extremes included
        '{tcw_pkg::OP_PUTC, 8'h41, 8'hFF, 11'h7FF, 1'b1, 11'd1, 8'h00, 8'h00},
        '{tcw_pkg::OP_PUTC, 8'hFF, 8'h00, 11'd0,   1'b1, 11'd2, 8'h00, 8'h00},
        '{tcw_pkg::OP_PUTC, 8'h00, 8'h00, 11'd0,   1'b1, 11'd3, 8'h00, 8'h00},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0, 1'b1, 11'd3, 8'h41, tcw_pkg::RESET_COLOR},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd1, 1'b1, 11'd3, 8'hFF, tcw_pkg::RESET_COLOR},
        // backspace blanks the cell it steps back onto
        '{tcw_pkg::OP_PUTC, tcw_pkg::CHAR_BACKSPACE, 8'h00, 11'd0, 1'b1, 11'd2,
          8'h00, 8'h00},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd2, 1'b1, 11'd2,
          tcw_pkg::CHAR_SPACE, tcw_pkg::RESET_COLOR},
        '{tcw_pkg::OP_PUTC, tcw_pkg::CHAR_NEWLINE, 8'h00, 11'd0, 1'b1, 11'd80,
          8'h00, 8'h00},
        '{tcw_pkg::OP_SAVE, 8'h00, 8'h00, 11'd0, 1'b1, 11'd80, 8'h00, 8'h00},
        // recolor keeps the characters
        '{tcw_pkg::OP_COLOR, 8'h00, 8'hFF, 11'd0, 1'b1, 11'd80, 8'h00, 8'h00},
        '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd0, 1'b1, 11'd80, 8'h41, 8'hFF},
        '{tcw_pkg::OP_COLOR, 8'h00, 8'h00, 11'd0, 1'b1, 11'd80, 8'h00, 8'h00},
        '{tcw_pkg::OP_PUTC,  8'h7A, 8'h00, 11'd0, 1'b1, 11'd81, 8'h00, 8'h00},
        // clear blanks with the pen color and homes the cursor
        '{tcw_pkg::OP_CLEAR, 8'h00, 8'h00, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00},
        '{tcw_pkg::OP_READ,  8'h00, 8'h00, 11'd80, 1'b1, 11'd0, tcw_pkg::CHAR_SPACE, 8'h00},
        // restore brings back the screen as saved, cursor stays put
        '{tcw_pkg::OP_RESTORE, 8'h00, 8'h00, 11'd0, 1'b1, 11'd0, 8'h00, 8'h00},
        '{tcw_pkg::OP_READ, 8'h00, 8'h00, 11'd0, 1'b1, 11'd0, 8'h41, tcw_pkg::RESET_COLOR},
        '{tcw_pkg::OP_COLOR, 8'h00, 8'h55, 11'd0, 1'b0, 11'd0, 8'h00, 8'h00}
    };

    text_console_writer_unit #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .char_code   (char_code),
        .color_value (color_value),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cursor_pos  (cursor_pos),
        .read_char   (read_char),
        .read_color  (read_color)
    );

    always #1 clk = ~clk;

    // blank cell in the current pen color
    function automatic tcw_pkg::cell_t blank_cell();
        return tcw_pkg::cell_t'{color: pen_color, ch: tcw_pkg::CHAR_SPACE};
    endfunction

    // every row moves up one, the last row is blanked
    function automatic void scroll_screen();
        for (int k = 0; k < LAST_ROW; k++)
            screen_img[k] = screen_img[k + NUM_COLS];
        for (int k = LAST_ROW; k < NUM_CELLS; k++)
            screen_img[k] = blank_cell();
    endfunction

    // applies one request to the console image and returns its answer
    function automatic answer_t predict_console(tcw_pkg::op_t req_op, tcw_pkg::byte_t req_ch,
                                                tcw_pkg::byte_t req_color,
                                                tcw_pkg::pos_t req_idx);
        answer_t a;
        a = '0;
        case (req_op)
            tcw_pkg::OP_PUTC:
            begin
                if (req_ch == tcw_pkg::CHAR_BACKSPACE)
                begin
                    if (cursor_now != 0)
                    begin
                        cursor_now = cursor_now - 1'b1;
                        screen_img[cursor_now] = blank_cell();
                    end
                end
                else if (req_ch == tcw_pkg::CHAR_NEWLINE)
                begin
                    if (cursor_now < LAST_ROW)
                        cursor_now = tcw_pkg::pos_t'(cursor_now + NUM_COLS
                                                     - (cursor_now % NUM_COLS));
                    else
                    begin
                        scroll_screen();
                        cursor_now = tcw_pkg::pos_t'(LAST_ROW);
                    end
                end
                else
                begin
                    screen_img[cursor_now] = tcw_pkg::cell_t'{color: pen_color, ch: req_ch};
                    // filling the last cell scrolls
                    if (cursor_now == NUM_CELLS - 1)
                    begin
                        scroll_screen();
                        cursor_now = tcw_pkg::pos_t'(LAST_ROW);
                    end
                    else
                        cursor_now = cursor_now + 1'b1;
                end
            end
            tcw_pkg::OP_CLEAR:
            begin
                for (int k = 0; k < NUM_CELLS; k++)
                    screen_img[k] = blank_cell();
                cursor_now = '0;
            end
            tcw_pkg::OP_COLOR:
            begin
                pen_color = req_color;
                for (int k = 0; k < NUM_CELLS; k++)
                    screen_img[k].color = req_color;
            end
            tcw_pkg::OP_SAVE:    backup_img = screen_img;
            tcw_pkg::OP_RESTORE: screen_img = backup_img;
            tcw_pkg::OP_READ:
            begin
                // out-of-range reads answer zero
                if (req_idx < NUM_CELLS)
                begin
                    a.ch  = screen_img[req_idx].ch;
                    a.col = screen_img[req_idx].color;
                end
            end
            default: ;
        endcase
        a.pos = cursor_now;
        return a;
    endfunction

    // random byte, never one of the control codes backspace and newline
    function automatic tcw_pkg::byte_t rand_glyph();
        tcw_pkg::byte_t c;
        do
            c = tcw_pkg::byte_t'($urandom_range(0, 255));
        while (c == tcw_pkg::CHAR_BACKSPACE || c == tcw_pkg::CHAR_NEWLINE);
        return c;
    endfunction

    // offers one request, keeps valid high across back-to-back requests,
    // and books its answer once the handshake completes
    task automatic send_request(input tcw_pkg::op_t req_op, input tcw_pkg::byte_t req_ch,
                                input tcw_pkg::byte_t req_color,
                                input tcw_pkg::pos_t req_idx,
                                input bit typed, input answer_t typed_answer);
        answer_t predicted;
        int      gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= req_op;
        char_code   <= req_ch;
        color_value <= req_color;
        cell_index  <= req_idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // the image always advances, typed rows just override the answer
        predicted = predict_console(req_op, req_ch, req_color, req_idx);
        pending_answers.push_back(typed ? typed_answer : predicted);
    endtask

    // one field of a result against its expectation
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // stimulus: reset, directed table, random traffic with a fill-to-scroll run
    initial
    begin : stimulus
        tcw_pkg::op_t   rq_op;
        tcw_pkg::byte_t rq_ch;
        tcw_pkg::byte_t rq_col;
        tcw_pkg::pos_t  rq_idx;
        int             pick;
        int             sel;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= tcw_pkg::OP_PUTC;
        char_code   <= '0;
        color_value <= '0;
        cell_index  <= '0;

        // predictor starts from the reset image
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            screen_img[k] = tcw_pkg::cell_t'{color: tcw_pkg::RESET_COLOR,
                                             ch: tcw_pkg::CHAR_SPACE};
            backup_img[k] = tcw_pkg::cell_t'{color: tcw_pkg::RESET_COLOR,
                                             ch: tcw_pkg::CHAR_SPACE};
        end
        cursor_now = '0;
        pen_color  = tcw_pkg::RESET_COLOR;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, sender mostly busy, receiver often stalled
        foreach (directed_steps[s])
            send_request(directed_steps[s].op, directed_steps[s].ch,
                         directed_steps[s].col, directed_steps[s].idx,
                         directed_steps[s].typed,
                         answer_t'{pos: directed_steps[s].want_pos,
                                   ch:  directed_steps[s].want_ch,
                                   col: directed_steps[s].want_col});

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            // idle phases: sender light / receiver heavy, swapped, then none
            if (n < RANDOM_COUNT / 3)
            begin
                tx_idle_pct = 9;
                rx_idle_pct = 60;
            end
            else if (n < 2 * RANDOM_COUNT / 3)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 9;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // walk down to the last row and type until the screen scrolls
            if (n == FILL_AT)
            begin
                while (cursor_now < LAST_ROW)
                    send_request(tcw_pkg::OP_PUTC, tcw_pkg::CHAR_NEWLINE,
                                 tcw_pkg::byte_t'($urandom_range(0, 255)),
                                 tcw_pkg::pos_t'($urandom_range(0, 2047)), 1'b0, '0);
                do
                    send_request(tcw_pkg::OP_PUTC, rand_glyph(),
                                 tcw_pkg::byte_t'($urandom_range(0, 255)),
                                 tcw_pkg::pos_t'($urandom_range(0, 2047)), 1'b0, '0);
                while (cursor_now != LAST_ROW);
            end

            // unused fields carry noise
            rq_op  = tcw_pkg::OP_PUTC;
            rq_ch  = tcw_pkg::byte_t'($urandom_range(0, 255));
            rq_col = tcw_pkg::byte_t'($urandom_range(0, 255));
            rq_idx = tcw_pkg::pos_t'($urandom_range(0, 2047));
            pick   = $urandom_range(0, 99);

            // mostly text with line breaks, some reads, a few full-screen ops
            if (pick < 58)
                rq_ch = rand_glyph();
            else if (pick < 68)
                rq_ch = tcw_pkg::CHAR_NEWLINE;
            else if (pick < 74)
                rq_ch = tcw_pkg::CHAR_BACKSPACE;
            else if (pick < 86)
            begin
                rq_op = tcw_pkg::OP_READ;
                sel   = $urandom_range(0, 9);
                if (sel < 5)
                    rq_idx = tcw_pkg::pos_t'($urandom_range(0, NUM_CELLS - 1));
                else if (sel < 9)
                    // recently written cells just behind the cursor
                    rq_idx = tcw_pkg::pos_t'((cursor_now + NUM_CELLS
                                              - $urandom_range(1, 100)) % NUM_CELLS);
                else
                    rq_idx = tcw_pkg::pos_t'($urandom_range(NUM_CELLS, 2047));
            end
            else if (pick < 89)
                rq_op = tcw_pkg::OP_COLOR;
            else if (pick < 91)
                rq_op = tcw_pkg::OP_CLEAR;
            else if (pick < 94)
                rq_op = tcw_pkg::OP_SAVE;
            else if (pick < 97)
                rq_op = tcw_pkg::OP_RESTORE;
            else
                rq_op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;

            send_request(rq_op, rq_ch, rq_col, rq_idx, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // drain, then give a stray result time to show up
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (NUM_CELLS + 10) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stalls plus one long hold-off that backs up the block
    initial
    begin : result_side
        answer_t want;
        int      hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                answers_seen++;
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, cursor_pos %0d read_char %0d read_color %0d",
                             $time, cursor_pos, read_char, read_color);
                    fail_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("cursor_pos", int'(want.pos), int'(cursor_pos));
                    check_field("read_char", int'(want.ch), int'(read_char));
                    check_field("read_color", int'(want.col), int'(read_color));
                end
                if (answers_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
